/* design/hall_rpm_speed_estimator_unit_defines.svh */
// Assertion macros shared by the hall speed estimator checkers.
`ifndef HALL_RPM_SPEED_ESTIMATOR_UNIT_DEFINES_SVH
`define HALL_RPM_SPEED_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and held off during rst.
`define HRSE_ASSERT_IMM(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hrse checker: same-cycle property failed");

// Next-cycle implication, checked on clk and held off during rst.
`define HRSE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hrse checker: next-cycle property failed");

`endif

/* design/hrse_pkg.sv */
// Shared types and constants of the hall speed estimator.
`default_nettype none
package hrse_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_STOP_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MEAS_WINDOW  = 2'd1;
  localparam logic [1:0] REG_MAGNETS      = 2'd2;
  localparam logic [1:0] REG_WHEEL_CIRC   = 2'd3;

  localparam logic [31:0] STOP_TIMEOUT_RST = 32'd1000000;
  localparam logic [20:0] MEAS_WINDOW_RST  = 21'd200000;
  localparam logic [6:0]  MAGNETS_RST      = 7'd1;
  localparam logic [13:0] WHEEL_CIRC_RST   = 14'd1500;

  localparam logic [29:0] RPM_SCALE     = 30'd600000000;
  localparam logic [2:0]  NEW_WEIGHT    = 3'd4;
  localparam logic [2:0]  OLD_WEIGHT    = 3'd6;
  localparam logic [3:0]  WEIGHT_SUM    = 4'd10;
  localparam logic [2:0]  SPEED_MUL     = 3'd6;
  localparam logic [16:0] SPEED_DIV     = 17'd100000;
  localparam logic [15:0] SAT16         = 16'hFFFF;
  // rpm_x10 at or above this gives a whole rpm above 65535
  localparam logic [31:0] WHOLE_SAT_LIM = 32'd655360;
  // rpm_x10 * circ * 6 at or above this gives a speed above 65535
  localparam logic [48:0] SPEED_SAT_LIM = 49'd6553600000;

  localparam int DEN_W = 39;
  localparam int NUM_W = 64;
  localparam int QUO_W = 32;

  typedef struct packed {
    logic [31:0] stop_timeout_us;
    logic [20:0] measure_window_us;
    logic [6:0]  magnets_per_rev;
    logic [13:0] wheel_circumference_mm;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic             short_mode;  // 16 quotient bits instead of 32
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

/* design/hrse_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module hrse_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hrse_pkg::div_req_t req,
  output hrse_pkg::div_rsp_t     rsp
);

  // caller guarantees the numerator's upper part is below the divisor
  logic [hrse_pkg::DEN_W-1:0] rem;
  logic [hrse_pkg::DEN_W-1:0] den;
  logic [hrse_pkg::QUO_W-1:0] quo;
  logic [4:0]                 cnt;
  logic                       busy;
  logic                       done;
  logic [hrse_pkg::DEN_W:0]   trial;
  logic                       fits;

  assign trial = {rem, quo[hrse_pkg::QUO_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        den  <= req.den;
        if (req.short_mode) begin
          rem <= req.num[54:16];
          quo <= {req.num[15:0], 16'd0};
          cnt <= 5'd15;
        end else begin
          rem <= {7'd0, req.num[63:32]};
          quo <= req.num[31:0];
          cnt <= 5'd31;
        end
      end else if (busy) begin
        rem <= fits ? hrse_pkg::DEN_W'(trial - {1'b0, den}) : trial[hrse_pkg::DEN_W-1:0];
        quo <= {quo[hrse_pkg::QUO_W-2:0], fits};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
`default_nettype wire

/* design/hrse_cfg.sv */
// APB register bank of the hall speed estimator.
`default_nettype none
module hrse_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output hrse_pkg::cfg_t   cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_timeout_us        <= hrse_pkg::STOP_TIMEOUT_RST;
      cfg.measure_window_us      <= hrse_pkg::MEAS_WINDOW_RST;
      cfg.magnets_per_rev        <= hrse_pkg::MAGNETS_RST;
      cfg.wheel_circumference_mm <= hrse_pkg::WHEEL_CIRC_RST;
    end else if (wr) begin
      unique case (paddr[3:2])
        hrse_pkg::REG_STOP_TIMEOUT: cfg.stop_timeout_us        <= pwdata;
        hrse_pkg::REG_MEAS_WINDOW:  cfg.measure_window_us      <= pwdata[20:0];
        hrse_pkg::REG_MAGNETS:      cfg.magnets_per_rev        <= pwdata[6:0];
        hrse_pkg::REG_WHEEL_CIRC:   cfg.wheel_circumference_mm <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hrse_pkg::REG_STOP_TIMEOUT: prdata = cfg.stop_timeout_us;
      hrse_pkg::REG_MEAS_WINDOW:  prdata = {11'd0, cfg.measure_window_us};
      hrse_pkg::REG_MAGNETS:      prdata = {25'd0, cfg.magnets_per_rev};
      hrse_pkg::REG_WHEEL_CIRC:   prdata = {18'd0, cfg.wheel_circumference_mm};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

/* design/hrse_core.sv */
// Sequencer, accumulators, smoothing and output register of the estimator.
`default_nettype none
module hrse_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire hrse_pkg::cfg_t cfg,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [71:0]    s_tdata,
  input  wire logic           s_tuser,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [63:0]         m_tdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ACC    = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_MEAS   = 4'd3;
  localparam logic [3:0] S_MWAIT  = 4'd4;
  localparam logic [3:0] S_SMOOTH = 4'd5;
  localparam logic [3:0] S_SWAIT  = 4'd6;
  localparam logic [3:0] S_OUT1   = 4'd7;
  localparam logic [3:0] S_WWAIT  = 4'd8;
  localparam logic [3:0] S_OUT2   = 4'd9;
  localparam logic [3:0] S_KWAIT  = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]  st;
  logic        hall_valid;
  logic [15:0] pulse_delta;
  logic [19:0] window_us;
  logic [31:0] pulse_age_us;
  logic [31:0] pulse_sum;
  logic [31:0] time_sum_us;
  logic [31:0] smoothed_rpm_x10;
  logic [31:0] meas;
  logic [63:0] num;
  logic [38:0] den;
  logic [15:0] rpm_whole;
  logic [15:0] speed_kmh_x10;

  logic        clear_cond;
  logic [32:0] pulse_add;
  logic [32:0] time_add;
  logic        meas_sat;
  logic [35:0] smooth_sum;
  logic [48:0] speed_prod;

  hrse_pkg::div_req_t div_req;
  hrse_pkg::div_rsp_t div_rsp;

  hrse_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready   = (st == S_IDLE);
  assign clear_cond = !hall_valid || (window_us == 20'd0) ||
                      (pulse_age_us >= cfg.stop_timeout_us);
  assign pulse_add  = {1'b0, pulse_sum} + {17'd0, pulse_delta};
  assign time_add   = {1'b0, time_sum_us} + {13'd0, window_us};
  // quotient overflows 32 bits exactly when num / 2^32 >= den
  assign meas_sat   = {7'd0, num[63:32]} >= den;
  assign smooth_sum = 36'(meas) * 36'(hrse_pkg::NEW_WEIGHT) +
                      36'(smoothed_rpm_x10) * 36'(hrse_pkg::OLD_WEIGHT);
  assign speed_prod = 49'(num[45:0]) * 49'(hrse_pkg::SPEED_MUL);

  always_comb begin
    div_req = '0;
    unique case (st)
      S_MEAS: begin
        div_req.start = (den != 39'd0) && !meas_sat;
        div_req.num   = num;
        div_req.den   = den;
      end
      S_SMOOTH: begin
        div_req.start = (smoothed_rpm_x10 != 32'd0);
        div_req.num   = 64'(smooth_sum);
        div_req.den   = 39'(hrse_pkg::WEIGHT_SUM);
      end
      S_OUT1: begin
        div_req.start      = smoothed_rpm_x10 < hrse_pkg::WHOLE_SAT_LIM;
        div_req.short_mode = 1'b1;
        div_req.num        = 64'(smoothed_rpm_x10);
        div_req.den        = 39'(hrse_pkg::WEIGHT_SUM);
      end
      S_OUT2: begin
        div_req.start      = speed_prod < hrse_pkg::SPEED_SAT_LIM;
        div_req.short_mode = 1'b1;
        div_req.num        = 64'(speed_prod);
        div_req.den        = 39'(hrse_pkg::SPEED_DIV);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st               <= S_IDLE;
      m_tvalid         <= 1'b0;
      pulse_sum        <= 32'd0;
      time_sum_us      <= 32'd0;
      smoothed_rpm_x10 <= 32'd0;
    end else begin
      // in S_DONE the output register is reloaded or held below
      if (m_tvalid && m_tready && (st != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            hall_valid   <= s_tuser;
            pulse_delta  <= s_tdata[15:0];
            window_us    <= s_tdata[35:16];
            pulse_age_us <= s_tdata[67:36];
            st           <= S_ACC;
          end
        end
        S_ACC: begin
          if (clear_cond) begin
            pulse_sum        <= 32'd0;
            time_sum_us      <= 32'd0;
            smoothed_rpm_x10 <= 32'd0;
            st               <= S_OUT1;
          end else begin
            pulse_sum   <= pulse_add[32] ? 32'hFFFF_FFFF : pulse_add[31:0];
            time_sum_us <= time_add[32] ? 32'hFFFF_FFFF : time_add[31:0];
            st          <= S_CHK;
          end
        end
        S_CHK: begin
          if (time_sum_us >= {11'd0, cfg.measure_window_us}) begin
            num         <= 64'(62'(pulse_sum) * 62'(hrse_pkg::RPM_SCALE));
            den         <= 39'(cfg.magnets_per_rev) * 39'(time_sum_us);
            pulse_sum   <= 32'd0;
            time_sum_us <= 32'd0;
            st          <= S_MEAS;
          end else begin
            st <= S_OUT1;
          end
        end
        S_MEAS: begin
          if (den == 39'd0) begin
            meas <= 32'd0;
            st   <= S_SMOOTH;
          end else if (meas_sat) begin
            meas <= 32'hFFFF_FFFF;
            st   <= S_SMOOTH;
          end else begin
            st <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (div_rsp.done) begin
            meas <= div_rsp.quo;
            st   <= S_SMOOTH;
          end
        end
        S_SMOOTH: begin
          if (smoothed_rpm_x10 == 32'd0) begin
            smoothed_rpm_x10 <= meas;
            st               <= S_OUT1;
          end else begin
            st <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (div_rsp.done) begin
            smoothed_rpm_x10 <= div_rsp.quo;
            st               <= S_OUT1;
          end
        end
        S_OUT1: begin
          num <= 64'(46'(smoothed_rpm_x10) * 46'(cfg.wheel_circumference_mm));
          if (smoothed_rpm_x10 >= hrse_pkg::WHOLE_SAT_LIM) begin
            rpm_whole <= hrse_pkg::SAT16;
            st        <= S_OUT2;
          end else begin
            st <= S_WWAIT;
          end
        end
        S_WWAIT: begin
          if (div_rsp.done) begin
            rpm_whole <= div_rsp.quo[15:0];
            st        <= S_OUT2;
          end
        end
        S_OUT2: begin
          if (speed_prod >= hrse_pkg::SPEED_SAT_LIM) begin
            speed_kmh_x10 <= hrse_pkg::SAT16;
            st            <= S_DONE;
          end else begin
            st <= S_KWAIT;
          end
        end
        S_KWAIT: begin
          if (div_rsp.done) begin
            speed_kmh_x10 <= div_rsp.quo[15:0];
            st            <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {speed_kmh_x10, rpm_whole, smoothed_rpm_x10};
            st       <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/hall_rpm_speed_estimator_unit.sv */
// Top level of the hall sensor wheel speed estimator.
// Each input request carries one hall report window; each one yields exactly one result
// request. An invalid report, a zero-length window or a pulse age at or above
// stop_timeout_us clears the pulse and time accumulators and the smoothed value and
// reports zero. Otherwise pulses and microseconds are summed (saturating at 32 bits);
// once the summed time reaches measure_window_us, rpm x10 is measured as
// pulses * 600000000 / (magnets_per_rev * time), saturated to 32 bits, smoothed as
// 0.4 new + 0.6 old (the first non-zero state takes the measurement directly), and the
// accumulators restart. Every result carries the smoothed rpm x10, the whole rpm and
// km/h x10 from wheel_circumference_mm, the last two saturated at 65535. All division
// runs through one bit-serial divider producing one quotient bit per cycle: a report
// that makes no new measurement or clears takes two 16-bit quotients, and one that
// measures and smooths two further 32-bit quotients; saturated or zero cases skip
// their division. One request is worked on at a time; a finished result sits in the
// output register, and the next input request is taken while it waits.
// Configuration goes over the APB port (registers at byte addresses 0, 4, 8 and 12)
// and may only be written while the block is idle.
`default_nettype none
module hall_rpm_speed_estimator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input reports
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // pulse_delta[15:0], window_us[35:16],
                                     // pulse_age_us[67:36], zero pad[71:68]
  input  wire logic        s_tuser,  // hall_valid
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,  // rpm_x10[31:0], rpm_whole[47:32],
                                     // speed_kmh_x10[63:48]
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  hrse_pkg::cfg_t cfg;

  hrse_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hrse_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

/* design/hrse_checker.sv */
// Port-level checker of the hall speed estimator, bound to the top level.
`default_nettype none
`include "hall_rpm_speed_estimator_unit_defines.svh"
module hrse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata
);

  // a stalled result holds
  `HRSE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // one request at a time: taking one drops ready
  `HRSE_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
  // zero rpm means zero whole rpm and zero speed
  `HRSE_ASSERT_IMM(a_zero_rpm, m_tvalid && (m_tdata[31:0] == 32'd0), m_tdata[63:32] == 32'd0)
  // whole rpm saturates once rpm x10 reaches 655360
  `HRSE_ASSERT_IMM(a_whole_sat, m_tvalid && (m_tdata[31:0] >= 32'd655360),
                   m_tdata[47:32] == 16'hFFFF)

endmodule

bind hall_rpm_speed_estimator_unit hrse_checker u_hrse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the hall sensor wheel speed estimator.
`timescale 1ns / 100ps

module tb_top;

  // Generous bound for the slowest correct run, roughly 1700 requests.
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_REPORTS = 150;

  // One hall report as carried on the input stream.
  typedef struct packed {
    logic        hall_valid;
    logic [15:0] pulse_delta;
    logic [19:0] window_us;
    logic [31:0] pulse_age_us;
  } hall_report_t;

  // One result, laid out exactly as m_tdata (speed in the top bits).
  typedef struct packed {
    logic [15:0] speed_kmh_x10;
    logic [15:0] rpm_whole;
    logic [31:0] rpm_x10;
  } speed_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // pulse_delta[15:0], window_us[35:16], pulse_age_us[67:36]
  logic        s_tuser = 1'b0;  // hall_valid
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;  // rpm_x10[31:0], rpm_whole[47:32], speed_kmh_x10[63:48]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hall_rpm_speed_estimator_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow of the block: register copy plus the two accumulators and the smoothed value.
  hrse_pkg::cfg_t live_cfg = '{hrse_pkg::STOP_TIMEOUT_RST, hrse_pkg::MEAS_WINDOW_RST,
                               hrse_pkg::MAGNETS_RST, hrse_pkg::WHEEL_CIRC_RST};
  logic [31:0] pulse_acc = '0;
  logic [31:0] time_acc = '0;
  logic [31:0] smooth_rpm = '0;

  speed_result_t pending_speeds[$];  // expected results, oldest first
  int mismatch_count = 0;
  int result_index = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top NOT OK");
    $finish;
  end

  // Predicts the result of one accepted report and advances the shadow state.
  function automatic speed_result_t estimate_speed(input hall_report_t r);
    logic [32:0]   sum;
    logic [63:0]   num;
    logic [38:0]   den;
    logic [63:0]   meas;
    logic [63:0]   blend;
    logic [63:0]   spd;
    speed_result_t res;
    if (!r.hall_valid || r.window_us == '0 || r.pulse_age_us >= live_cfg.stop_timeout_us) begin
      // no wheel signal: everything restarts from zero
      pulse_acc  = '0;
      time_acc   = '0;
      smooth_rpm = '0;
    end else begin
      sum = {1'b0, pulse_acc} + {17'd0, r.pulse_delta};
      pulse_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      sum = {1'b0, time_acc} + {13'd0, r.window_us};
      time_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (time_acc >= {11'd0, live_cfg.measure_window_us}) begin
        num  = 64'(pulse_acc) * 64'(hrse_pkg::RPM_SCALE);
        den  = 39'(live_cfg.magnets_per_rev) * 39'(time_acc);
        meas = (den == '0) ? 64'd0 : num / 64'(den);
        if (meas > 64'hFFFF_FFFF) meas = 64'hFFFF_FFFF;
        pulse_acc = '0;
        time_acc  = '0;
        if (smooth_rpm == '0) begin
          smooth_rpm = meas[31:0];
        end else begin
          blend = (64'(hrse_pkg::NEW_WEIGHT) * meas +
                   64'(hrse_pkg::OLD_WEIGHT) * 64'(smooth_rpm))
                  / 64'(hrse_pkg::WEIGHT_SUM);
          smooth_rpm = blend[31:0];
        end
      end
    end
    res.rpm_x10   = smooth_rpm;
    res.rpm_whole = (smooth_rpm / 32'd10 > 32'd65535) ? 16'hFFFF : 16'(smooth_rpm / 32'd10);
    spd = 64'(smooth_rpm) * 64'(live_cfg.wheel_circumference_mm) * 64'(hrse_pkg::SPEED_MUL)
          / 64'(hrse_pkg::SPEED_DIV);
    res.speed_kmh_x10 = (spd > 64'd65535) ? 16'hFFFF : spd[15:0];
    return res;
  endfunction

  function automatic hall_report_t report(input logic valid, input logic [15:0] delta,
                                          input logic [19:0] win, input logic [31:0] age);
    hall_report_t r;
    r.hall_valid   = valid;
    r.pulse_delta  = delta;
    r.window_us    = win;
    r.pulse_age_us = age;
    return r;
  endfunction

  // Sends one report; valid stays high into the next request when there is no gap.
  task automatic send_report(input hall_report_t r);
    int gap;
    bit taken;
    gap = sender_idles ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.hall_valid;
    s_tdata  <= {4'b0000, r.pulse_age_us, r.window_us, r.pulse_delta};
    // ready is looked at mid-cycle, where it is settled, and taken at the next edge
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    pending_speeds.push_back(estimate_speed(r));
  endtask

  // Sender stops and waits until every result has been taken; block is then idle.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready; shadow copy masked to width.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    bit ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    case (idx)
      hrse_pkg::REG_STOP_TIMEOUT: live_cfg.stop_timeout_us        = value;
      hrse_pkg::REG_MEAS_WINDOW:  live_cfg.measure_window_us      = value[20:0];
      hrse_pkg::REG_MAGNETS:      live_cfg.magnets_per_rev        = value[6:0];
      hrse_pkg::REG_WHEEL_CIRC:   live_cfg.wheel_circumference_mm = value[13:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] tmo, input logic [31:0] win,
                            input logic [31:0] mag, input logic [31:0] circ);
    write_register(hrse_pkg::REG_STOP_TIMEOUT, tmo);
    write_register(hrse_pkg::REG_MEAS_WINDOW, win);
    write_register(hrse_pkg::REG_MAGNETS, mag);
    write_register(hrse_pkg::REG_WHEEL_CIRC, circ);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s on result %0d: expected %0d, got %0d",
               field, result_index, want, got);
  endtask

  // Result side: random stalls on tready, each taken result checked against the oldest
  // prediction.
  initial begin : result_checker
    speed_result_t got;
    speed_result_t want;
    int stall;
    bit taken;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(negedge clk);
        taken = m_tvalid;
        got   = m_tdata;
        @(posedge clk);
      end while (!taken);
      if (pending_speeds.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing expected: %h", result_index, got);
      end else begin
        want = pending_speeds.pop_front();
        if (got.rpm_x10 !== want.rpm_x10)
          note_mismatch("rpm_x10", want.rpm_x10, got.rpm_x10);
        if (got.rpm_whole !== want.rpm_whole)
          note_mismatch("rpm_whole", 32'(want.rpm_whole), 32'(got.rpm_whole));
        if (got.speed_kmh_x10 !== want.speed_kmh_x10)
          note_mismatch("speed_kmh_x10", 32'(want.speed_kmh_x10), 32'(got.speed_kmh_x10));
      end
      result_index++;
    end
  end

  // Reset register values; each way of clearing, accumulation, first measurement,
  // smoothing, and whole rpm and speed saturating.
  task automatic test_reset_values_and_clears();
    send_report(report(1'b0, 16'hFFFF, 20'hFFFFF, 32'd0));       // invalid reading
    send_report(report(1'b1, 16'd10, 20'd0, 32'd0));             // zero-length window
    send_report(report(1'b1, 16'd10, 20'd5000, 32'd1000000));    // age exactly at timeout
    send_report(report(1'b1, 16'd10, 20'd100000, 32'd999999));   // window not reached
    send_report(report(1'b1, 16'd10, 20'd100000, 32'd0));        // first measurement
    send_report(report(1'b1, 16'd30, 20'd200000, 32'd5000));     // smoothed
    send_report(report(1'b1, 16'd0, 20'd200000, 32'd77));        // no pulses, decays
    send_report(report(1'b1, 16'hFFFF, 20'd1, 32'd0));
    send_report(report(1'b1, 16'hFFFF, 20'hFFFFF, 32'd12));      // whole and speed saturate
    send_report(report(1'b1, 16'd1, 20'd1, 32'hFFFF_FFFF));      // stale
    hold_until_drained();
  endtask

  // Huge measurement clipped to 32 bits, then blended with a small one.
  task automatic test_measurement_saturation();
    set_config(32'hFFFF_FFFF, 32'd1, 32'd1, 32'd10000);
    send_report(report(1'b1, 16'hFFFF, 20'd1, 32'd0));
    send_report(report(1'b1, 16'd1, 20'd1000000, 32'hFFFF_FFFE));
    send_report(report(1'b1, 16'd0, 20'd1, 32'd0));
    send_report(report(1'b1, 16'd7, 20'hFFFFF, 32'hFFFF_FFFF));  // stale even at max timeout
    hold_until_drained();
  endtask

  // Zero magnets per revolution: measurement reads as zero and pulls the average down.
  task automatic test_zero_magnets();
    set_config(hrse_pkg::STOP_TIMEOUT_RST, 32'd1000, 32'd1, 32'(hrse_pkg::WHEEL_CIRC_RST));
    send_report(report(1'b1, 16'd50, 20'd1000, 32'd10));
    hold_until_drained();
    write_register(hrse_pkg::REG_MAGNETS, 32'd0);
    send_report(report(1'b1, 16'd50, 20'd1000, 32'd10));
    send_report(report(1'b1, 16'd5, 20'd500, 32'd0));
    send_report(report(1'b1, 16'd5, 20'd500, 32'd0));
    hold_until_drained();
  endtask

  // Measurement window of zero (upper bits of the write fall away): every report measures.
  task automatic test_zero_measure_window();
    write_register(hrse_pkg::REG_MEAS_WINDOW, 32'hFFE0_0000);
    write_register(hrse_pkg::REG_MAGNETS, 32'h8000_0003);
    send_report(report(1'b1, 16'd0, 20'd1, 32'd0));
    send_report(report(1'b1, 16'd3, 20'd7, 32'd100));
    send_report(report(1'b1, 16'hFFFF, 20'hFFFFF, 32'd999));
    send_report(report(1'b1, 16'd1, 20'd3, 32'd0));
    hold_until_drained();
  endtask

  // Zero stop timeout: every report is stale.
  task automatic test_zero_stop_timeout();
    write_register(hrse_pkg::REG_STOP_TIMEOUT, 32'd0);
    send_report(report(1'b1, 16'd100, 20'd5000, 32'd0));
    send_report(report(1'b1, 16'hFFFF, 20'hFFFFF, 32'd0));
    hold_until_drained();
  endtask

  // Mostly well-formed reports sized so measurements come every few requests; the rest
  // are invalid readings, empty windows and stale pulses.
  function automatic hall_report_t random_report();
    hall_report_t r;
    logic [31:0]  tmo;
    logic [19:0]  cap;
    int           pick;
    tmo = live_cfg.stop_timeout_us;
    if (live_cfg.measure_window_us == '0)
      cap = 20'd1;
    else if (live_cfg.measure_window_us > 21'hFFFFF)
      cap = 20'hFFFFF;
    else
      cap = live_cfg.measure_window_us[19:0];
    r.hall_valid = 1'b1;
    pick = $urandom_range(0, 9);
    if (pick < 5)
      r.pulse_delta = 16'($urandom_range(0, 200));
    else if (pick < 8)
      r.pulse_delta = 16'($urandom_range(0, 5000));
    else
      r.pulse_delta = 16'($urandom);
    if ($urandom_range(0, 9) < 6)
      r.window_us = 20'($urandom_range(1, cap));
    else
      r.window_us = 20'($urandom_range(1, 20'hFFFFF));
    if (tmo == '0)
      r.pulse_age_us = $urandom;
    else if ($urandom_range(0, 9) < 7)
      r.pulse_age_us = $urandom_range(0, (tmo > 32'd2000000) ? 32'd2000000 : tmo - 32'd1);
    else
      r.pulse_age_us = $urandom % tmo;
    pick = $urandom_range(0, 99);
    if (pick >= 95) begin
      r.pulse_age_us = tmo + $urandom_range(0, 32'hFFFF_FFFF - tmo);
    end else if (pick >= 90) begin
      r.window_us = '0;
    end else if (pick >= 85) begin
      r.hall_valid   = 1'b0;
      r.pulse_delta  = 16'($urandom);
      r.window_us    = 20'($urandom);
      r.pulse_age_us = $urandom;
    end
    return r;
  endfunction

  // First phases pin the register extremes, later ones draw settings at random.
  task automatic pick_phase_config(input int phase);
    logic [31:0] tmo, win, mag, circ;
    case ($urandom_range(0, 3))
      0: tmo = 32'hFFFF_FFFF;
      1: tmo = $urandom;
      2: tmo = $urandom_range(1000, 2000000);
      default: tmo = hrse_pkg::STOP_TIMEOUT_RST;
    endcase
    case ($urandom_range(0, 4))
      0: win = 32'd1;
      1: win = 32'd2000000;
      2: win = $urandom_range(1, 5000);
      3: win = $urandom_range(1, 2000000);
      default: win = 32'(hrse_pkg::MEAS_WINDOW_RST);
    endcase
    case ($urandom_range(0, 3))
      0: mag = 32'd1;
      1: mag = 32'd64;
      2: mag = $urandom_range(1, 64);
      default: mag = $urandom_range(0, 127);
    endcase
    case ($urandom_range(0, 3))
      0: circ = 32'd0;
      1: circ = 32'd10000;
      2: circ = $urandom_range(0, 10000);
      default: circ = $urandom_range(0, 16383);
    endcase
    case (phase)
      0: set_config(32'hFFFF_FFFF, 32'd1, 32'd64, 32'h0000_3FFF);
      1: set_config(32'd1000000, 32'd2000000, 32'd1, 32'd0);
      2: set_config(tmo, 32'h001F_FFFF, 32'hFFFF_FF7F, 32'd10000);
      default: set_config(tmo, win, mag, circ);
    endcase
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_phase_config(phase);
      // every third phase runs back to back on both sides
      sender_idles   = (phase % 3) != 0;
      receiver_idles = (phase % 3) != 0;
      for (int n = 0; n < PHASE_REPORTS; n++) begin
        if (n == PHASE_REPORTS / 2) hold_until_drained();
        send_report(random_report());
      end
      hold_until_drained();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_values_and_clears();
    test_measurement_saturation();
    test_zero_magnets();
    test_zero_measure_window();
    test_zero_stop_timeout();
    test_random_traffic();
    hold_until_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_speeds.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
